[hw/rtl/mal_pkg.sv]
// Shared constants, operation codes and types for the MAC allow list table.
package mal_pkg;

    localparam int ENTRIES = 16;
    localparam int ADDR_W  = 48;
    localparam int FUNC_W  = 2;
    localparam int OUT_CNT_W = 5;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    // Operation held in the input register
    typedef struct packed {
        logic              go;
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] mac;
    } mal_req_t;

    // Outcome of one operation, before it is registered
    typedef struct packed {
        logic                 op_ok;
        logic                 present;
        logic                 granted;
        logic [OUT_CNT_W-1:0] entry_count;
    } mal_rsp_t;

endpackage

[hw/rtl/mal_if.sv]
// Valid/ready channel interfaces for operations and results.
interface mal_in_if
    import mal_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] mac;

    modport source (output valid, output func, output mac, input ready);
    modport sink   (input valid, input func, input mac, output ready);
endinterface

interface mal_out_if
    import mal_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 op_ok;
    logic                 present;
    logic                 granted;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, output op_ok, output present, output granted,
                    output entry_count, input ready);
    modport sink   (input valid, input op_ok, input present, input granted,
                    input entry_count, output ready);
endinterface

[hw/rtl/mac_allow_list_table.sv]
// Top level of the MAC allow list table: channel registers and control.
//
// Usage:
//   req carries one operation per transfer: func (lookup, add, delete one,
//   clear all) and a 48-bit mac. rsp returns one result per operation:
//   op_ok, present, granted and entry_count, in operation order.
//   cfg_we/cfg_wdata write check_mode; write it only while the block is idle.
//   A request passes through the input register, then the result register,
//   before its result is offered.
//   Throughput: one operation per cycle while rsp is not held. The match
//   across all slots, the lowest-free-slot pick and the count update sit in
//   the logic between the input register and the result register, so the
//   next operation sees the table left by the previous one.
//   Reset: every slot is invalid, the count is zero, check_mode is zero and
//   both registers are empty. Slot addresses are not cleared.
//   Stall: while rsp is held, the result register holds and the input
//   register holds one more operation; req.ready drops only when both are
//   full.
module mac_allow_list_table
    import mal_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  logic   cfg_wdata,
    mal_in_if.sink   req,
    mal_out_if.source rsp
);

    logic              check_mode_reg;
    logic              in_valid_reg;
    logic [FUNC_W-1:0] in_func_reg;
    logic [ADDR_W-1:0] in_mac_reg;
    logic              out_valid_reg;
    logic              advance;
    mal_req_t          tbl_req;
    mal_rsp_t          tbl_rsp;
    mal_rsp_t          out_reg;

    // Advance the held operation whenever the result register can take it
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            check_mode_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_func_reg <= req.func;
            in_mac_reg  <= req.mac;
        end
    end

    assign tbl_req.go   = advance;
    assign tbl_req.func = in_func_reg;
    assign tbl_req.mac  = in_mac_reg;

    mal_slot_table u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_mode (check_mode_reg),
        .req        (tbl_req),
        .rsp        (tbl_rsp)
    );

    // Result register: load on advance, drop once the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= tbl_rsp;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.op_ok       = out_reg.op_ok;
    assign rsp.present     = out_reg.present;
    assign rsp.granted     = out_reg.granted;
    assign rsp.entry_count = out_reg.entry_count;

    // A failed add or delete always concerns an absent address
    a_fail_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.op_ok) |-> !out_reg.present)
        else $error("failed operation reported a present address");

    // A present address is always granted
    a_present_granted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.present) |-> out_reg.granted)
        else $error("present address not granted");

    // A held operation that cannot advance stays in the input register
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_mac_reg)
                                        && $stable(in_func_reg)))
        else $error("stalled operation lost from input register");

    // Requests stall only when both registers are full and the output is blocked
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (in_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request stalled without output back-pressure");

endmodule

[hw/rtl/mal_slot_table.sv]
// Slot store with parallel match, free-slot pick and count update.
module mal_slot_table
    import mal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     check_mode,
    input  mal_req_t req,
    output mal_rsp_t rsp
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ADDR_W-1:0]  addr_reg [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] free_oh;
    logic               hit;
    logic               full;
    logic               do_add;
    logic [CNT_W+OUT_CNT_W-1:0] count_wide;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (addr_reg[i] == req.mac);
        end
    end

    // Lowest clear bit of the valid vector
    assign free_oh = ~valid_reg & (valid_reg + ENTRIES'(1));
    assign hit     = |match;
    assign full    = &valid_reg;

    assign count_wide = {{OUT_CNT_W{1'b0}}, count_next};

    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        do_add      = 1'b0;
        rsp.op_ok   = 1'b1;
        rsp.present = hit;
        rsp.granted = !check_mode || hit;
        unique case (req.func)
            FUNC_LOOKUP:
            begin
            end
            FUNC_ADD:
            begin
                if (!hit)
                begin
                    if (full)
                    begin
                        rsp.op_ok = 1'b0;
                    end
                    else
                    begin
                        do_add     = 1'b1;
                        valid_next = valid_reg | free_oh;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            FUNC_DELETE:
            begin
                if (hit)
                begin
                    valid_next = valid_reg & ~match;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    rsp.op_ok = 1'b0;
                end
            end
            FUNC_CLEAR:
            begin
                valid_next  = '0;
                count_next  = '0;
                rsp.present = 1'b0;
                rsp.granted = 1'b0;
            end
            default:
            begin
            end
        endcase
        rsp.entry_count = count_wide[OUT_CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (req.go)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Address store: written only into the picked free slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (req.go && do_add && free_oh[i])
            begin
                addr_reg[i] <= req.mac;
            end
        end
    end

endmodule
